// File: design/ula_pkg.sv
// Shared types and constants for the UART line assembler.
`default_nettype none
package ula_pkg;

  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_AW    = 1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [1:0] {
    OP_BYTE       = 2'd0,
    OP_FETCH      = 2'd1,
    OP_FETCH_NONE = 2'd2
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic [7:0]        rx_byte;
    logic [SIZE_W-1:0] buf_room;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic        has_line;
    logic [7:0]  line_char;
    logic        last;
    logic [31:0] byte_count;
    logic [7:0]  recent_byte;
  } result_t;

endpackage
`default_nettype wire

// File: design/ula_in_if.sv
// Input channel: received bytes and fetch requests.
`default_nettype none
interface ula_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  rx_byte;
  logic [15:0] buf_room;

  modport source (output valid, output kind, output rx_byte, output buf_room, input ready);
  modport sink   (input valid, input kind, input rx_byte, input buf_room, output ready);
endinterface
`default_nettype wire

// File: design/ula_out_if.sv
// Output channel: fetched line characters and status.
`default_nettype none
interface ula_out_if;
  logic        valid;
  logic        ready;
  logic        has_line;
  logic [7:0]  line_char;
  logic        last;
  logic [31:0] byte_count;
  logic [7:0]  recent_byte;

  modport source (output valid, output has_line, output line_char, output last,
                  output byte_count, output recent_byte, input ready);
  modport sink   (input valid, input has_line, input line_char, input last,
                  input byte_count, input recent_byte, output ready);
endinterface
`default_nettype wire

// File: design/ula_front.sv
// Front end: accepts input words, classifies them into commands.
`default_nettype none
module ula_front import ula_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ula_in_if.sink         in_i,
  output logic           push_o,
  output cmd_t           cmd_o,
  input  wire q_status_t q_status_i
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic accept;

  assign push_o     = valid_q && !q_status_i.full;
  assign in_i.ready = !valid_q || push_o;
  assign accept     = in_i.valid && in_i.ready;
  assign cmd_o      = cmd_q;

  always_comb begin
    cmd_d          = cmd_q;
    cmd_d.rx_byte  = in_i.rx_byte;
    cmd_d.buf_room = in_i.buf_room;
    if (!in_i.kind) begin
      cmd_d.op = OP_BYTE;
    end else if (in_i.buf_room == '0) begin
      cmd_d.op = OP_FETCH_NONE;
    end else begin
      cmd_d.op = OP_FETCH;
    end
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

endmodule
`default_nettype wire

// File: design/ula_cmd_fifo.sv
// Short command queue between front end and back end.
`default_nettype none
module ula_cmd_fifo import ula_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output q_status_t status_o
);

  cmd_t               entry_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMDQ_AW:0]   count_q, count_d;

  assign cmd_o           = entry_q[rd_ptr_q];
  assign status_o.empty  = (count_q == '0);
  assign status_o.full   = (count_q == (CMDQ_AW+1)'(CMDQ_DEPTH));

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// File: design/ula_back.sv
// Back end: line state, line buffer memory, readout and output register.
`default_nettype none
module ula_back import ula_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      pop_o,
  ula_out_if.source out_o
);

  localparam int unsigned LW = $clog2(LINE_CAPACITY);
  localparam logic [LW-1:0] LEN_MAX = LW'(LINE_CAPACITY - 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic          done_q, done_d;
  logic [31:0]   total_q, total_d;
  logic [7:0]    prev_q, prev_d;
  logic [LW-1:0] idx_q, idx_d;
  logic [LW-1:0] n_last_q, n_last_d;
  logic [31:0]   snap_total_q;
  logic [7:0]    snap_prev_q;
  logic          snap_en;
  logic          rd_pend_q, rd_pend_d;
  logic          rd_last_q;
  logic [7:0]    rd_data_q;
  logic          out_valid_q, out_valid_d;
  result_t       out_q, out_d;

  logic [7:0]    mem_q [LINE_CAPACITY];
  logic          mem_we;

  logic              out_free, load_rd, load_empty, issue;
  logic [SIZE_W-1:0] size_m1;
  logic [LW-1:0]     n;
  logic              fetch_empty;

  assign out_free = !out_valid_q || out_o.ready;
  assign load_rd  = rd_pend_q && out_free;
  assign issue    = (state_q == ST_STREAM) && (!rd_pend_q || load_rd);

  assign size_m1 = cmd_i.buf_room - 1'b1;
  assign n       = (SIZE_W'(len_q) >= cmd_i.buf_room) ? size_m1[LW-1:0] : len_q;
  assign fetch_empty = (cmd_i.op == OP_FETCH_NONE) || !done_q || (n == '0);

  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    done_d     = done_q;
    total_d    = total_q;
    prev_d     = prev_q;
    idx_d      = idx_q;
    n_last_d   = n_last_q;
    snap_en    = 1'b0;
    mem_we     = 1'b0;
    pop_o      = 1'b0;
    load_empty = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op) inside
            OP_BYTE: begin
              pop_o   = 1'b1;
              total_d = total_q + 1'b1;
              prev_d  = cmd_i.rx_byte;
              if (!done_q) begin
                if (cmd_i.rx_byte == CHAR_CR || cmd_i.rx_byte == CHAR_LF) begin
                  if (len_q != '0) begin
                    done_d = 1'b1;
                  end
                end else if (len_q < LEN_MAX) begin
                  mem_we = 1'b1;
                  len_d  = len_q + 1'b1;
                end else begin
                  // overflow: drop the partial line
                  len_d = '0;
                end
              end
            end
            OP_FETCH, OP_FETCH_NONE: begin
              if (fetch_empty) begin
                if (!rd_pend_q && out_free) begin
                  pop_o      = 1'b1;
                  load_empty = 1'b1;
                  // truncated to nothing still clears the finished line
                  if (cmd_i.op == OP_FETCH && done_q) begin
                    done_d = 1'b0;
                    len_d  = '0;
                  end
                end
              end else if (!rd_pend_q) begin
                // hold until the previous line's last word has left the read stage
                pop_o    = 1'b1;
                snap_en  = 1'b1;
                idx_d    = '0;
                n_last_d = n - 1'b1;
                done_d   = 1'b0;
                len_d    = '0;
                state_d  = ST_STREAM;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_STREAM: begin
        if (issue) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == n_last_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    rd_pend_d = rd_pend_q;
    if (issue) begin
      rd_pend_d = 1'b1;
    end else if (load_rd) begin
      rd_pend_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_rd) begin
      out_valid_d       = 1'b1;
      out_d.has_line    = 1'b1;
      out_d.line_char   = rd_data_q;
      out_d.last        = rd_last_q;
      out_d.byte_count  = snap_total_q;
      out_d.recent_byte = snap_prev_q;
    end else if (load_empty) begin
      out_valid_d       = 1'b1;
      out_d.has_line    = 1'b0;
      out_d.line_char   = 8'h00;
      out_d.last        = 1'b1;
      out_d.byte_count  = total_q;
      out_d.recent_byte = prev_q;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      done_q      <= 1'b0;
      total_q     <= '0;
      prev_q      <= '0;
      idx_q       <= '0;
      n_last_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      done_q      <= done_d;
      total_q     <= total_d;
      prev_q      <= prev_d;
      idx_q       <= idx_d;
      n_last_q    <= n_last_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (snap_en) begin
      snap_total_q <= total_q;
      snap_prev_q  <= prev_q;
    end
  end

  // line buffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[len_q] <= cmd_i.rx_byte;
    end
    if (issue) begin
      rd_data_q <= mem_q[idx_q];
      rd_last_q <= (idx_q == n_last_q);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.has_line    = out_q.has_line;
  assign out_o.line_char   = out_q.line_char;
  assign out_o.last        = out_q.last;
  assign out_o.byte_count  = out_q.byte_count;
  assign out_o.recent_byte = out_q.recent_byte;

endmodule
`default_nettype wire

// File: design/uart_line_assembler.sv
// Top level of the UART line assembler.
//
//   port    dir  payload                                            handshake
//   in_i    in   kind, rx_byte, buf_room                            valid/ready
//   out_o   out  has_line, line_char, last, byte_count, recent_byte valid/ready
//
// Received bytes stream at one per cycle while no line fetch holds the back end.
// A fetch of a finished line gives one word per character (at most buf_room - 1) at one
// per cycle while out_o.ready holds; the registered single read port sets that pace.
// Input words pass an input register and a two-entry command queue first.
// Reset clears all control state at once; the line buffer is not cleared.
// Output stalls back up through the queue to in_i.ready.
`default_nettype none
module uart_line_assembler import ula_pkg::*; #(
  parameter int unsigned LINE_CAPACITY = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ula_in_if.sink    in_i,
  ula_out_if.source out_o
);

  logic      push;
  cmd_t      front_cmd;
  cmd_t      queue_cmd;
  q_status_t q_status;
  logic      pop;

  ula_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .push_o     (push),
    .cmd_o      (front_cmd),
    .q_status_i (q_status)
  );

  ula_cmd_fifo u_cmd_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (front_cmd),
    .pop_i    (pop),
    .cmd_o    (queue_cmd),
    .status_o (q_status)
  );

  ula_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!q_status.empty),
    .cmd_i       (queue_cmd),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.has_line |-> out_o.last && (out_o.line_char == 8'h00))
    else $error("empty result without last mark or with a character");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |-> !q_status.full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("command queue underflow");

endmodule
`default_nettype wire

// File: test/tb_uart_line_assembler.sv
// Self-checking testbench for the UART line assembler: bytes, line fetches and stalls.
module tb_uart_line_assembler;
  timeunit 1ns;
  timeprecision 1ps;
  import ula_pkg::*;

  localparam logic        KIND_BYTE    = 1'b0;
  localparam logic        KIND_FETCH   = 1'b1;
  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned RAND_WORDS   = 255;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned HOLD_AFTER   = 20;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned IDLE_PCT     = 11;

  typedef struct packed {
    logic        kind;
    logic [7:0]  rx_byte;
    logic [15:0] buf_room;
  } in_word_t;

  logic clk_i;
  logic rst_ni;

  ula_in_if  in_if ();
  ula_out_if out_if ();

  uart_line_assembler #(.LINE_CAPACITY(CAPACITY)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  in_word_t    pending_words[$];
  result_t     expected_words[$];

  // Line state as the block should hold it
  logic [7:0]  line_buf[CAPACITY];
  int unsigned line_len;
  bit          line_ready;
  logic [31:0] rx_total;
  logic [7:0]  rx_last;

  int          errors;
  int unsigned words_in;
  int unsigned words_out;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned rand_count;
  result_t     want_word;
  logic        calm;

  // No idling on either side over a window of the run
  assign calm = (words_in >= 150) && (words_in < 230);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic predict_word(input logic kind, input logic [7:0] b, input logic [15:0] size);
    int unsigned n;
    result_t     r;
    if (kind == KIND_BYTE) begin
      rx_total = rx_total + 32'd1;
      rx_last  = b;
      if (line_ready) return;
      if (b == CHAR_CR || b == CHAR_LF) begin
        if (line_len > 0) line_ready = 1'b1;
      end else if (line_len < CAPACITY - 1) begin
        line_buf[line_len] = b;
        line_len++;
      end else begin
        line_len = 0;
      end
      return;
    end
    r.byte_count  = rx_total;
    r.recent_byte = rx_last;
    r.has_line    = 1'b0;
    r.line_char   = 8'h00;
    r.last        = 1'b1;
    if (!line_ready || size == 16'd0) begin
      expected_words.push_back(r);
      return;
    end
    n = line_len;
    if (n >= size) n = size - 1;
    if (n > CAPACITY - 1) n = CAPACITY - 1;
    line_ready = 1'b0;
    line_len   = 0;
    if (n == 0) begin
      expected_words.push_back(r);
      return;
    end
    for (int unsigned i = 0; i < n; i++) begin
      r.has_line  = 1'b1;
      r.line_char = line_buf[i];
      r.last      = (i + 1 == n);
      expected_words.push_back(r);
    end
  endtask

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic push_byte(input logic [7:0] b);
    in_word_t w;
    w.kind     = KIND_BYTE;
    w.rx_byte  = b;
    w.buf_room = 16'($urandom_range(0, 65535));
    pending_words.push_back(w);
  endtask

  task automatic push_fetch(input logic [15:0] size);
    in_word_t w;
    w.kind     = KIND_FETCH;
    w.rx_byte  = 8'($urandom_range(0, 255));
    w.buf_room = size;
    pending_words.push_back(w);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  task automatic push_line(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) push_byte(text_byte());
    push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    rand_count += len + 1;
  endtask

  task automatic build_directed();
    push_fetch(16'd100);              // nothing finished yet
    push_byte(CHAR_CR);               // empty line: ignore
    push_byte(CHAR_LF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CHAR_LF);
    push_byte(8'h41);                 // line waits: drop this byte
    push_fetch(16'd0);                // no room: line keeps waiting
    push_fetch(16'hFFFF);
    push_byte(8'h41);
    push_byte(8'h42);
    push_byte(8'h43);
    push_byte(CHAR_CR);
    push_fetch(16'd1);                // truncated to nothing, line still cleared
    push_fetch(16'd50);
    push_byte(8'h55);
    push_byte(8'hAA);
    push_byte(8'h7F);
    push_byte(8'h80);
    push_byte(CHAR_CR);
    push_fetch(16'd3);
    push_fetch(16'hFFFF);
  endtask

  task automatic build_random();
    int unsigned seq;
    int unsigned pick;
    int unsigned len;
    logic [15:0] size;
    seq = 0;
    while (rand_count < RAND_WORDS) begin
      pick = $urandom_range(0, 99);
      if (seq == 0) pick = 0;
      if (seq == 1) pick = 70;
      if (pick < 80) begin
        if (pick < 70)
          len = (seq == 0 || $urandom_range(0, 15) == 0) ? CAPACITY - 1 : $urandom_range(1, 12);
        else
          len = $urandom_range(CAPACITY, CAPACITY + 8);   // overruns and restarts the line
        if ($urandom_range(0, 4) == 0) begin
          push_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
          rand_count++;
        end
        push_line(len);
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 3)) begin
            push_byte(8'($urandom_range(0, 255)));
            rand_count++;
          end
        case ($urandom_range(0, 7))
          0:       size = 16'd0;
          1:       size = 16'd1;
          2:       size = 16'(len);
          3:       size = 16'(len + 1);
          4:       size = 16'($urandom_range(2, len + 1));
          5:       size = 16'($urandom_range(0, 65535));
          default: size = 16'($urandom_range(len + 2, 300));
        endcase
        if (seq == 0) size = 16'hFFFF;
        push_fetch(size);
        rand_count++;
        if (size == 16'd0) begin
          push_fetch(16'hFFFF);
          rand_count++;
        end
      end else if (pick < 90) begin
        push_fetch(16'($urandom_range(0, 65535)));
        rand_count++;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          push_byte(8'($urandom_range(0, 255)));
          rand_count++;
        end
      end
      seq++;
    end
  endtask

  // Driver: offer the next word, hold it until taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid    <= 1'b0;
      in_if.kind     <= KIND_BYTE;
      in_if.rx_byte  <= 8'h00;
      in_if.buf_room <= 16'd0;
    end else if (!in_if.valid || in_if.ready) begin
      if (pending_words.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_if.valid    <= 1'b1;
        in_if.kind     <= pending_words[0].kind;
        in_if.rx_byte  <= pending_words[0].rx_byte;
        in_if.buf_room <= pending_words[0].buf_room;
        void'(pending_words.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && words_out >= HOLD_AFTER) begin
      out_if.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      out_if.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // Monitor: predict on accepted input, check accepted output
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_word(in_if.kind, in_if.rx_byte, in_if.buf_room);
        words_in <= words_in + 1;
      end
      if (out_if.valid && out_if.ready) begin
        words_out <= words_out + 1;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual has_line=%0d char=%h last=%0d",
                   $time, out_if.has_line, out_if.line_char, out_if.last);
          errors++;
        end else begin
          want_word = expected_words.pop_front();
          check_field("has_line", want_word.has_line, out_if.has_line);
          check_field("line_char", want_word.line_char, out_if.line_char);
          check_field("last", want_word.last, out_if.last);
          check_field("byte_count", want_word.byte_count, out_if.byte_count);
          check_field("recent_byte", want_word.recent_byte, out_if.recent_byte);
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.kind      = KIND_BYTE;
    in_if.rx_byte   = 8'h00;
    in_if.buf_room  = 16'd0;
    out_if.ready    = 1'b0;
    errors          = 0;
    words_in        = 0;
    words_out       = 0;
    line_len        = 0;
    line_ready      = 1'b0;
    rx_total        = 32'd0;
    rx_last         = 8'h00;
    rand_count      = 0;
    build_directed();
    build_random();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (pending_words.size() > 0 || in_if.valid || expected_words.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
design/ula_pkg.sv
design/ula_in_if.sv
design/ula_out_if.sv
design/ula_front.sv
design/ula_cmd_fifo.sv
design/ula_back.sv
design/uart_line_assembler.sv
test/tb_uart_line_assembler.sv
